/* rtl/core/apsc_pkg.sv */
// ----------------------------------------------------------------------------
// apsc_pkg
// Shared constants, types and byte classification functions for the archive
// path safety checker.
// ----------------------------------------------------------------------------
package apsc_pkg;

   // Longest path, in bytes, that can still pass.
   localparam int MAX_PATH_BYTES = 1024;

   // The byte counter stops at MAX_PATH_BYTES + 1, so it must hold that value.
   localparam int COUNT_WIDTH = $clog2(MAX_PATH_BYTES + 2);

   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;
   localparam logic [7:0] CHAR_LT        = 8'h3C;
   localparam logic [7:0] CHAR_GT        = 8'h3E;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_PIPE      = 8'h7C;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;

   // Allowed range of the byte that follows a UTF-8 lead byte.
   typedef enum logic [2:0] {
      RANGE_NORMAL = 3'd0,  // 0x80..0xBF
      RANGE_A0_BF  = 3'd1,  // after 0xE0, rules out overlong forms
      RANGE_80_9F  = 3'd2,  // after 0xED, rules out surrogates
      RANGE_90_BF  = 3'd3,  // after 0xF0, rules out overlong forms
      RANGE_80_8F  = 3'd4   // after 0xF4, stays at or below U+10FFFF
   } cont_range_type;

   typedef struct packed {
      logic           ok;
      logic [1:0]     pending;
      cont_range_type second_range;
   } lead_type;

   function automatic logic forbidden_byte(logic [7:0] b);
      return (b < CHAR_SPACE) || (b == CHAR_DEL) || (b == CHAR_LT) ||
             (b == CHAR_GT) || (b == CHAR_COLON) || (b == CHAR_QUOTE) ||
             (b == CHAR_PIPE) || (b == CHAR_QUESTION) || (b == CHAR_STAR) ||
             (b == CHAR_BACKSLASH);
   endfunction

   function automatic logic continuation_ok(logic [7:0] b, cont_range_type r);
      logic ok;
      case (r)
         RANGE_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
         RANGE_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
         RANGE_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
         RANGE_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
         default:     ok = (b >= 8'h80) && (b <= 8'hBF);
      endcase
      return ok;
   endfunction

   // Classifies a byte that starts a new character.
   function automatic lead_type take_lead(logic [7:0] b);
      lead_type r;
      r.ok           = 1'b1;
      r.pending      = 2'd0;
      r.second_range = RANGE_NORMAL;
      if (b < 8'h80) begin
         r.pending = 2'd0;
      end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
         r.pending = 2'd1;
      end else if (b == 8'hE0) begin
         r.pending      = 2'd2;
         r.second_range = RANGE_A0_BF;
      end else if (b == 8'hED) begin
         r.pending      = 2'd2;
         r.second_range = RANGE_80_9F;
      end else if ((b >= 8'hE1) && (b <= 8'hEF)) begin
         r.pending = 2'd2;
      end else if (b == 8'hF0) begin
         r.pending      = 2'd3;
         r.second_range = RANGE_90_BF;
      end else if (b == 8'hF4) begin
         r.pending      = 2'd3;
         r.second_range = RANGE_80_8F;
      end else if ((b >= 8'hF1) && (b <= 8'hF3)) begin
         r.pending = 2'd3;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

/* rtl/core/archive_path_safety_checker.sv */
// ----------------------------------------------------------------------------
// archive_path_safety_checker
// Checks an archive entry path, one byte per item, and reports one safe or
// unsafe verdict on the item that ends the path.
//
// The request channel (req_*) carries one path byte per item, with req_last
// on the final item. An item with req_no_byte set carries no byte: with
// req_last it ends the path (alone, it is an empty path and fails), without
// req_last it is dropped. req_allow_directory is sampled on the first item
// of each path and permits a trailing slash.
// The response channel (rsp_*) carries one item per path, rsp_path_safe.
// Every byte is checked in the cycle it is accepted, and the verdict on the
// last item is registered in the output register; the block takes one item
// every cycle while req_stall is low.
// A second result register catches one verdict while the output register is
// stalled; the request side stalls only while that register is full, and
// items that end no path keep flowing as long as it is empty.
// Reset is synchronous and active high: it empties both result registers and
// puts the path state back to the start of a new path.
// ----------------------------------------------------------------------------
module archive_path_safety_checker (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_path_byte,
   input  logic       req_allow_directory,
   input  logic       req_no_byte,
   input  logic       req_last,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_path_safe
);
   import apsc_pkg::*;

   // Per-path state. It describes everything seen since the first byte.
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic                   failed_ff, failed_in;
   logic                   at_path_start_ff, at_path_start_in;
   logic [7:0]             previous_byte_ff, previous_byte_in;
   logic [1:0]             utf8_pending_ff, utf8_pending_in;
   cont_range_type         utf8_range_ff, utf8_range_in;
   logic                   dir_allowed_ff, dir_allowed_in;

   // Output register and the skid register behind it.
   logic out_valid_ff, out_valid_in;
   logic out_safe_ff, out_safe_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_safe_ff, skid_safe_in;

   logic     accept;
   logic     take_item;
   logic     take_byte;
   logic     push;
   logic     pop;
   logic     dir_eff;
   logic     byte_fail;
   logic     cont_good;
   lead_type lead;
   logic     verdict;

   // The path after this item, before the end-of-path clear.
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   failed_next;
   logic [7:0]             prev_next;
   logic [1:0]             pending_next;
   cont_range_type         range_next;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   // A byteless item that does not end the path changes nothing.
   assign take_item = accept && !(req_no_byte && !req_last);
   assign take_byte = take_item && !req_no_byte;
   assign push      = take_item && req_last;
   assign pop       = out_valid_ff && !rsp_stall;

   // The directory permission is taken from the first item of a path.
   assign dir_eff = at_path_start_ff ? req_allow_directory : dir_allowed_ff;

   always_comb begin
      lead      = take_lead(req_path_byte);
      cont_good = continuation_ok(req_path_byte, utf8_range_ff);

      // A slash may neither open the path nor close an empty segment or one
      // that ends in a dot or a space.
      byte_fail = forbidden_byte(req_path_byte);
      if (req_path_byte == CHAR_SLASH) begin
         if (at_path_start_ff || (previous_byte_ff == CHAR_SLASH) ||
             (previous_byte_ff == CHAR_DOT) || (previous_byte_ff == CHAR_SPACE)) begin
            byte_fail = 1'b1;
         end
      end

      // UTF-8 tracking. A byte that breaks an open sequence fails the path and
      // is then read again as a new lead byte.
      if ((utf8_pending_ff != 2'd0) && cont_good) begin
         pending_next = utf8_pending_ff - 2'd1;
         range_next   = RANGE_NORMAL;
      end else begin
         pending_next = lead.pending;
         range_next   = lead.second_range;
         if ((utf8_pending_ff != 2'd0) || !lead.ok) begin
            byte_fail = 1'b1;
         end
      end

      if (take_byte) begin
         failed_next = failed_ff || byte_fail;
         prev_next   = req_path_byte;
         if (byte_count_ff <= COUNT_WIDTH'(MAX_PATH_BYTES)) begin
            count_next = byte_count_ff + COUNT_WIDTH'(1);
         end else begin
            count_next = byte_count_ff;
         end
      end else begin
         failed_next  = failed_ff;
         prev_next    = previous_byte_ff;
         count_next   = byte_count_ff;
         pending_next = utf8_pending_ff;
         range_next   = utf8_range_ff;
      end

      // Verdict on the path as it stands after this item.
      verdict = !failed_next && (count_next != '0) &&
                (count_next <= COUNT_WIDTH'(MAX_PATH_BYTES)) &&
                (pending_next == 2'd0);
      if (count_next != '0) begin
         if ((prev_next == CHAR_DOT) || (prev_next == CHAR_SPACE)) begin
            verdict = 1'b0;
         end
         if ((prev_next == CHAR_SLASH) && !dir_eff) begin
            verdict = 1'b0;
         end
      end
   end

   // Next path state: hold when idle, advance on a byte, clear on a verdict.
   always_comb begin
      byte_count_in    = byte_count_ff;
      failed_in        = failed_ff;
      at_path_start_in = at_path_start_ff;
      previous_byte_in = previous_byte_ff;
      utf8_pending_in  = utf8_pending_ff;
      utf8_range_in    = utf8_range_ff;
      dir_allowed_in   = dir_allowed_ff;
      if (take_item) begin
         dir_allowed_in = dir_eff;
         if (req_last) begin
            byte_count_in    = '0;
            failed_in        = 1'b0;
            at_path_start_in = 1'b1;
            previous_byte_in = 8'h00;
            utf8_pending_in  = 2'd0;
            utf8_range_in    = RANGE_NORMAL;
         end else begin
            byte_count_in    = count_next;
            failed_in        = failed_next;
            at_path_start_in = 1'b0;
            previous_byte_in = prev_next;
            utf8_pending_in  = pending_next;
            utf8_range_in    = range_next;
         end
      end
   end

   // Result registers. A new verdict goes to the output register when it is
   // free or being drained, otherwise into the skid register. No push can
   // arrive while the skid register is full, since the request side stalls.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_safe_in   = out_safe_ff;
      skid_valid_in = skid_valid_ff;
      skid_safe_in  = skid_safe_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_safe_in   = skid_safe_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_safe_in  = verdict;
         end else begin
            skid_valid_in = 1'b1;
            skid_safe_in  = verdict;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         failed_ff        <= 1'b0;
         at_path_start_ff <= 1'b1;
         previous_byte_ff <= 8'h00;
         utf8_pending_ff  <= 2'd0;
         utf8_range_ff    <= RANGE_NORMAL;
         dir_allowed_ff   <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         byte_count_ff    <= byte_count_in;
         failed_ff        <= failed_in;
         at_path_start_ff <= at_path_start_in;
         previous_byte_ff <= previous_byte_in;
         utf8_pending_ff  <= utf8_pending_in;
         utf8_range_ff    <= utf8_range_in;
         dir_allowed_ff   <= dir_allowed_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_safe_ff  <= out_safe_in;
      skid_safe_ff <= skid_safe_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_path_safe = out_safe_ff;

   // The skid register only fills behind a full output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register is empty");

   // An item that ends a path leaves a verdict on the response channel.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> rsp_valid)
      else $error("path ended without a verdict");

   // After a verdict the next path starts from a clean state.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=>
         (at_path_start_ff && (byte_count_ff == '0) && !failed_ff &&
          (utf8_pending_ff == 2'd0)))
      else $error("path state not cleared after a verdict");

   // The byte counter saturates one past the limit.
   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= COUNT_WIDTH'(MAX_PATH_BYTES + 1))
      else $error("byte counter ran past its saturation value");

endmodule
